/* src/lsa_pkg.sv */
// Shared constants and controller/datapath interface types for the LRU slot allocator.
package lsa_pkg;

	// Sizing of the slot store and the domain space
	localparam int NUM_BLOCKS  = 16;
	localparam int MAX_DOMAINS = 256;
	localparam int SLOT_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);

	// Fixed field widths
	localparam int ID_W       = 8;
	localparam int OUT_SLOT_W = 4;
	localparam int DC_W       = 9;
	localparam int SL_W       = 5;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT   = 1'd1;

	// Reset values of the configuration registers
	localparam logic [DC_W-1:0] DOMAIN_COUNT_RST = 9'd256;
	localparam logic [SL_W-1:0] SLOT_LIMIT_RST   = 5'd16;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
		logic load_out;
	} lsa_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;
	} lsa_status_t;

endpackage

/* src/lsa_ctrl.sv */
// Controller state machine that sequences each request through lookup and update.
module lsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lsa_pkg::lsa_status_t status,
	output lsa_pkg::lsa_cmd_t    cmd
);
	import lsa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_nxt  = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end else begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* src/lsa_datapath.sv */
// Datapath: configuration, slot tags, recency order, fill count and the output register.
module lsa_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsa_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [lsa_pkg::ID_W-1:0]       domain_id,
	input  lsa_pkg::lsa_cmd_t              cmd,
	output lsa_pkg::lsa_status_t           status,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           hit,
	output logic [lsa_pkg::OUT_SLOT_W-1:0] slot,
	output logic                           range_error
);
	import lsa_pkg::*;

	// Configuration and captured request
	logic [DC_W-1:0]   dc_q;
	logic [SL_W-1:0]   sl_q;
	logic [ID_W-1:0]   id_q;
	logic [CNT_W-1:0]  filled_q;

	// Slot store: owner tag and recency order, least recent first
	logic [ID_W-1:0]   owner_q [NUM_BLOCKS];
	logic [SLOT_W-1:0] order_q [NUM_BLOCKS];

	// Lookup results
	logic              hit_q;
	logic              err_q;
	logic              fill_q;
	logic [SLOT_W-1:0] slot_q;

	// Output register
	logic                  out_valid_q;
	logic                  out_hit_q;
	logic                  out_err_q;
	logic [OUT_SLOT_W-1:0] out_slot_q;

	logic [DC_W-1:0]       eff_dom;
	logic [DC_W-1:0]       lim;
	logic [DC_W-1:0]       cap;
	logic                  err_c;
	logic                  full_c;
	logic [NUM_BLOCKS-1:0] match;
	logic                  hit_c;
	logic [SLOT_W-1:0]     hit_slot;
	logic [SLOT_W-1:0]     res_slot;
	logic [NUM_BLOCKS-1:0] posm;
	logic [NUM_BLOCKS-1:0] ge;
	logic [CNT_W-1:0]      last_pos;
	logic [SLOT_W-1:0]     order_nxt [NUM_BLOCKS];
	logic [SLOT_W-1:0]     fill_idx;

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign hit             = out_hit_q;
	assign slot            = out_slot_q;
	assign range_error     = out_err_q;
	assign fill_idx        = filled_q[SLOT_W-1:0];
	assign last_pos        = filled_q - CNT_W'(1);

	// Capacity: the smallest of the slot limit, the domain count and the slot store
	always_comb begin
		eff_dom = (32'(dc_q) > MAX_DOMAINS) ? DC_W'(MAX_DOMAINS) : dc_q;
		lim     = (sl_q != '0 && 32'(sl_q) < NUM_BLOCKS) ? DC_W'(sl_q) : DC_W'(NUM_BLOCKS);
		cap     = (eff_dom < lim) ? eff_dom : lim;
		err_c   = (DC_W'(id_q) >= eff_dom) || (cap == '0);
		full_c  = DC_W'(filled_q) >= cap;
	end

	// Parallel tag compare across the filled slots
	always_comb begin
		hit_slot = '0;
		for (int s = 0; s < NUM_BLOCKS; s++) begin
			match[s] = (CNT_W'(s) < filled_q) && (owner_q[s] == id_q);
			if (match[s]) begin
				hit_slot = hit_slot | SLOT_W'(s);
			end
		end
		hit_c    = |match;
		res_slot = hit_c ? hit_slot : (!full_c ? fill_idx : order_q[0]);
	end

	// Promotion: entries from the chosen position onwards move down one place
	always_comb begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			posm[i] = (CNT_W'(i) < filled_q) && (order_q[i] == slot_q);
		end
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			ge[i] = 1'b0;
			for (int j = 0; j <= i; j++) begin
				ge[i] = ge[i] | posm[j];
			end
		end
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			if (!ge[i]) begin
				order_nxt[i] = order_q[i];
			end else if (i < NUM_BLOCKS - 1 && CNT_W'(i + 1) < filled_q) begin
				order_nxt[i] = order_q[(i + 1) % NUM_BLOCKS];
			end else if (CNT_W'(i) == last_pos) begin
				order_nxt[i] = slot_q;
			end else begin
				order_nxt[i] = order_q[i];
			end
		end
	end

	// Control registers: configuration, fill count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q        <= DOMAIN_COUNT_RST;
			sl_q        <= SLOT_LIMIT_RST;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DOMAIN_COUNT: dc_q <= cfg_wdata[DC_W-1:0];
					REG_SLOT_LIMIT:   sl_q <= cfg_wdata[SL_W-1:0];
					default:          ;
				endcase
				filled_q <= '0;
			end else if (cmd.update && !err_q && fill_q) begin
				filled_q <= filled_q + CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, lookup results, slot store, output data
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q <= domain_id;
		end
		if (cmd.lookup) begin
			err_q  <= err_c;
			hit_q  <= hit_c && !err_c;
			fill_q <= !hit_c && !full_c && !err_c;
			slot_q <= err_c ? '0 : res_slot;
		end
		if (cmd.update && !err_q) begin
			if (fill_q) begin
				owner_q[fill_idx] <= id_q;
				order_q[fill_idx] <= slot_q;
			end else begin
				if (!hit_q) begin
					owner_q[slot_q] <= id_q;
				end
				for (int i = 0; i < NUM_BLOCKS; i++) begin
					order_q[i] <= order_nxt[i];
				end
			end
		end
		if (cmd.load_out) begin
			out_hit_q  <= hit_q;
			out_err_q  <= err_q;
			out_slot_q <= OUT_SLOT_W'(slot_q);
		end
	end

endmodule

/* src/lru_slot_allocator.sv */
// Top level of the LRU slot allocator: controller and datapath.
//
// Channel   Direction  Handshake            Payload
// in        request    in_valid/in_ready    domain_id
// out       result     out_valid/out_ready  hit, slot, range_error
// cfg       write      cfg_we               cfg_index, cfg_wdata
//
// A request is accepted only in the idle state. Its result enters the output register
// after the controller's lookup state (tag compare) and update state (recency update);
// the next request is taken only once the controller is back in idle, so requests do
// not overlap.
// Reset restores domain_count 256, slot_limit 16 and an empty slot store.
// A held result does not stall the recency update; the controller waits only at the hand-off to the output register.
module lru_slot_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsa_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lsa_pkg::ID_W-1:0]       domain_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [lsa_pkg::OUT_SLOT_W-1:0] slot,
	output logic                           range_error
);
	import lsa_pkg::*;

	lsa_cmd_t    cmd;
	lsa_status_t status;

	// Sequencing of each request
	lsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Storage, compare and recency logic
	lsa_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.domain_id   (domain_id),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.hit         (hit),
		.slot        (slot),
		.range_error (range_error)
	);

endmodule

/* src/lsa_checker.sv */
// Port-level checker for the LRU slot allocator and its bind to the top level.
module lsa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           hit,
	input logic [lsa_pkg::OUT_SLOT_W-1:0] slot,
	input logic                           range_error
);
	import lsa_pkg::*;

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(slot)
			&& $stable(range_error))
		else $error("result changed while stalled");

	// An out-of-range request carries zero in the other fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> !hit && (slot == '0))
		else $error("range error with non-zero hit or slot");

	// One request at a time: none is taken in the cycle after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// A request keeps the input closed through both the lookup and the update state
	a_busy_two: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !in_ready)
		else $error("request accepted before the update completed");

endmodule

bind lru_slot_allocator lsa_checker u_lsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.hit         (hit),
	.slot        (slot),
	.range_error (range_error)
);
